// ===== design/mspg_pkg.sv =====
// mspg_pkg: shared constants for the multiplexed servo pulse generator
// register indexes, reset values and field widths; no dependencies

package mspg_pkg;

    // parameter defaults
    localparam int NUM_SERVOS_DEF = 5;
    localparam int NUM_SLOTS_DEF  = 5;

    // fixed field widths
    localparam int TICK_W   = 16;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 2;

    // register indexes on the configuration port
    typedef enum logic [CFG_AW-1:0] {
        REG_SLOT_PERIOD  = 2'd0,
        REG_MIN_POSITION = 2'd1,
        REG_MAX_POSITION = 2'd2
    } cfg_reg_t;

    // set command status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_RANGE     = 2'd2
    } set_status_t;

    // item kind carried on tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // reset values
    localparam logic [TICK_W-1:0] SLOT_PERIOD_RST  = 16'd64000;
    localparam logic [TICK_W-1:0] MIN_POSITION_RST = 16'd16800;
    localparam logic [TICK_W-1:0] MAX_POSITION_RST = 16'd31200;
    localparam logic [TICK_W-1:0] RESET_POSITION   = 16'd24000;
    localparam logic [TICK_W-1:0] IDLE_COMPARE     = 16'hFFFF;

endpackage

// ===== design/multiplexed_servo_pulse_generator.sv =====
// multiplexed_servo_pulse_generator: time-multiplexed RC servo pulse generator
// depends on mspg_pkg
//
// result: an accepted item's result is held in the output register from the cycle after it is accepted
// throughput: one item per cycle; s_tready drops only while a result waits on m_tready
// reset: synchronous active-low aresetn; counter and slot cleared, all positions
// at 1.5 ms, servo zero pin high, configuration registers at their reset values

module multiplexed_servo_pulse_generator
    import mspg_pkg::*;
#(
    parameter int NUM_SERVOS = NUM_SERVOS_DEF,
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // servo_index[2:0], position_value[18:3], zero pad
    input  logic                  s_tuser,   // cmd
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((NUM_SERVOS+STATUS_W+7)/8)*8-1:0] m_tdata // pin_levels, set_status, zero pad
);

    localparam int OUT_W   = NUM_SERVOS + STATUS_W;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;
    localparam int IDX_W   = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

    // configuration registers
    logic [TICK_W-1:0] slot_period_reg;
    logic [TICK_W-1:0] min_position_reg;
    logic [TICK_W-1:0] max_position_reg;

    // generator state
    logic [TICK_W-1:0]     tick_count_reg,    tick_count_next;
    logic [SLOT_W-1:0]     slot_index_reg,    slot_index_next;
    logic [TICK_W-1:0]     compare_value_reg, compare_value_next;
    logic [NUM_SERVOS-1:0] pin_state_reg,     pin_state_next;
    logic [TICK_W-1:0]     positions_reg [NUM_SERVOS];

    // output register
    logic              m_tvalid_reg;
    logic [OUT_TW-1:0] m_tdata_reg;

    // input fields
    logic              in_cmd;
    logic [SLOT_W-1:0] in_servo_index;
    logic [TICK_W-1:0] in_position;
    logic              accept;

    assign in_cmd         = s_tuser;
    assign in_servo_index = s_tdata[SLOT_W-1:0];
    assign in_position    = s_tdata[SLOT_W+TICK_W-1:SLOT_W];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // tick step: counter, slot advance, compare latch, pin update
    logic [TICK_W:0]       tick_inc;
    logic [TICK_W-1:0]     period;
    logic                  wrap;
    logic [SLOT_W:0]       slot_inc;
    logic                  servo_slot;
    logic [NUM_SERVOS-1:0] slot_onehot;
    logic [NUM_SERVOS-1:0] pin_tick;
    logic [TICK_W-1:0]     cmp_tick;

    always_comb begin
        tick_inc = {1'b0, tick_count_reg} + 1'b1;
        period   = (slot_period_reg == '0) ? TICK_W'(1) : slot_period_reg;
        wrap     = (tick_inc >= {1'b0, period});
        slot_inc = {1'b0, slot_index_reg} + 1'b1;

        if (wrap) begin
            tick_count_next = '0;
            slot_index_next = (slot_inc >= (SLOT_W+1)'(NUM_SLOTS)) ? '0 : slot_inc[SLOT_W-1:0];
        end else begin
            tick_count_next = tick_inc[TICK_W-1:0];
            slot_index_next = slot_index_reg;
        end

        servo_slot = ({1'b0, slot_index_next} < (SLOT_W+1)'(NUM_SERVOS));
        for (int i = 0; i < NUM_SERVOS; i++) begin
            slot_onehot[i] = (slot_index_next == SLOT_W'(i));
        end

        pin_tick = pin_state_reg;
        cmp_tick = compare_value_reg;
        if (wrap) begin
            if (servo_slot) begin
                pin_tick = pin_tick | slot_onehot;
                cmp_tick = positions_reg[slot_index_next[IDX_W-1:0]];
            end else begin
                cmp_tick = IDLE_COMPARE;
            end
        end
        if (servo_slot && (tick_count_next == cmp_tick)) begin
            pin_tick = pin_tick & ~slot_onehot;
        end
        compare_value_next = cmp_tick;
        pin_state_next     = pin_tick;
    end

    // set command check
    set_status_t set_status;
    logic        set_write;

    always_comb begin
        set_write = 1'b0;
        priority if ({1'b0, in_servo_index} >= (SLOT_W+1)'(NUM_SERVOS)) begin
            set_status = ST_BAD_INDEX;
        end else if (in_position < min_position_reg || in_position > max_position_reg) begin
            set_status = ST_RANGE;
        end else begin
            set_status = ST_OK;
            set_write  = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_period_reg  <= SLOT_PERIOD_RST;
            min_position_reg <= MIN_POSITION_RST;
            max_position_reg <= MAX_POSITION_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SLOT_PERIOD:  slot_period_reg  <= cfg_wr_data;
                REG_MIN_POSITION: min_position_reg <= cfg_wr_data;
                REG_MAX_POSITION: max_position_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // generator state and stored positions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= '0;
            slot_index_reg    <= '0;
            compare_value_reg <= RESET_POSITION;
            pin_state_reg     <= NUM_SERVOS'(1);
            for (int i = 0; i < NUM_SERVOS; i++) begin
                positions_reg[i] <= RESET_POSITION;
            end
        end else if (accept) begin
            if (in_cmd == CMD_TICK) begin
                tick_count_reg    <= tick_count_next;
                slot_index_reg    <= slot_index_next;
                compare_value_reg <= compare_value_next;
                pin_state_reg     <= pin_state_next;
            end else if (set_write) begin
                positions_reg[in_servo_index[IDX_W-1:0]] <= in_position;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (in_cmd == CMD_TICK) begin
                m_tdata_reg <= OUT_TW'({ST_OK, pin_state_next});
            end else begin
                m_tdata_reg <= OUT_TW'({set_status, pin_state_reg});
            end
        end
    end

endmodule
